/* sv/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define TFE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

// The condition must never hold outside reset.
`define TFE_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

`endif

/* sv/tfe_pkg.sv */
`default_nettype none

package tfe_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Meaning of the input kind flag.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SOF_FIRST     = 2'd0;
   localparam logic [1:0] CSR_SOF_SECOND    = 2'd1;
   localparam logic [1:0] CSR_PROTO_VERSION = 2'd2;
   localparam logic [1:0] CSR_MAX_PAYLOAD   = 2'd3;

   // Byte positions inside the frame header.
   localparam logic [3:0] HDR_SOF_FIRST  = 4'd0;
   localparam logic [3:0] HDR_SOF_SECOND = 4'd1;
   localparam logic [3:0] HDR_VERSION    = 4'd2;
   localparam logic [3:0] HDR_TYPE       = 4'd3;
   localparam logic [3:0] HDR_FLAGS      = 4'd4;
   localparam logic [3:0] HDR_SEQ_LO     = 4'd5;
   localparam logic [3:0] HDR_SEQ_HI     = 4'd6;
   localparam logic [3:0] HDR_LEN_LO     = 4'd7;
   localparam logic [3:0] HDR_LEN_HI     = 4'd8;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_ERR   = 2'd2
   } op_type;

   // One classified command. For a payload byte, code carries the byte.
   typedef struct packed {
      op_type      op;
      logic        close;
      logic [7:0]  code;
      logic [7:0]  flags;
      logic [15:0] len;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic push;
      logic pop;
   } q_stat_type;

   typedef enum logic [2:0] {
      PH_HEAD   = 3'b001,
      PH_CRC_LO = 3'b010,
      PH_CRC_HI = 3'b100
   } phase_type;

   // CRC-16/CCITT-FALSE update by one byte, MSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* sv/tfe_front.sv */
`default_nettype none

// Classifies each accepted input beat into a command and tracks frame state.
module tfe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             kind,
   input  wire logic [7:0]       record_type,
   input  wire logic [7:0]       frame_flags,
   input  wire logic [15:0]      payload_len,
   input  wire logic [7:0]       payload_byte,
   input  wire logic [15:0]      max_payload,
   output tfe_pkg::cmd_type      cmd
);

   logic        in_frame_ff, in_frame_in;
   logic [15:0] bytes_left_ff, bytes_left_in;

   always_comb begin
      cmd           = '0;
      cmd.op        = tfe_pkg::OP_ERR;
      cmd.close     = 1'b1;
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      if (kind == tfe_pkg::KIND_START) begin
         // A new start abandons any open frame.
         in_frame_in   = 1'b0;
         bytes_left_in = '0;
         if (payload_len <= max_payload) begin
            cmd.op    = tfe_pkg::OP_START;
            cmd.close = (payload_len == 16'd0);
            cmd.code  = record_type;
            cmd.flags = frame_flags;
            cmd.len   = payload_len;
            if (payload_len != 16'd0) begin
               in_frame_in   = 1'b1;
               bytes_left_in = payload_len;
            end
         end
      end else if (in_frame_ff) begin
         cmd.op        = tfe_pkg::OP_BYTE;
         cmd.close     = (bytes_left_ff == 16'd1);
         cmd.code      = payload_byte;
         bytes_left_in = bytes_left_ff - 16'd1;
         if (bytes_left_ff == 16'd1) begin
            in_frame_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

`default_nettype wire

/* sv/tfe_queue.sv */
`default_nettype none

// Small command FIFO between the classifier and the byte sequencer.
module tfe_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tfe_pkg::cmd_type   push_cmd,
   input  wire logic               pop,
   output tfe_pkg::cmd_type        head_cmd,
   output tfe_pkg::q_stat_type     stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tfe_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.push  = push;
   assign stat.pop   = pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* sv/tfe_back.sv */
`default_nettype none

// Byte sequencer: expands commands into frame bytes, keeps the CRC and the
// sequence number, and drives the registered result channel.
module tfe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire tfe_pkg::cmd_type  head_cmd,
   output logic                   pop,
   input  wire logic [7:0]        sof_first,
   input  wire logic [7:0]        sof_second,
   input  wire logic [7:0]        proto_version,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   tfe_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in, crc_base;
   logic [15:0] seq_ff, seq_in;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff;
   logic        last_ff, err_ff;
   logic        fire, feed;
   logic [7:0]  byte_out;
   logic        end_out, err_out;

   assign fire = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      seq_in   = seq_ff;
      pop      = 1'b0;
      feed     = 1'b0;
      byte_out = '0;
      end_out  = 1'b0;
      err_out  = 1'b0;
      if (fire) begin
         case (phase_ff)
            tfe_pkg::PH_HEAD: begin
               case (head_cmd.op)
                  tfe_pkg::OP_START: begin
                     case (idx_ff)
                        tfe_pkg::HDR_SOF_FIRST:  byte_out = sof_first;
                        tfe_pkg::HDR_SOF_SECOND: byte_out = sof_second;
                        tfe_pkg::HDR_VERSION:    byte_out = proto_version;
                        tfe_pkg::HDR_TYPE:       byte_out = head_cmd.code;
                        tfe_pkg::HDR_FLAGS:      byte_out = head_cmd.flags;
                        tfe_pkg::HDR_SEQ_LO:     byte_out = seq_ff[7:0];
                        tfe_pkg::HDR_SEQ_HI:     byte_out = seq_ff[15:8];
                        tfe_pkg::HDR_LEN_LO:     byte_out = head_cmd.len[7:0];
                        tfe_pkg::HDR_LEN_HI:     byte_out = head_cmd.len[15:8];
                        default:                 byte_out = '0;
                     endcase
                     feed = (idx_ff >= tfe_pkg::HDR_VERSION);
                     if (idx_ff == tfe_pkg::HDR_LEN_HI) begin
                        idx_in = tfe_pkg::HDR_SOF_FIRST;
                        if (head_cmd.close) begin
                           phase_in = tfe_pkg::PH_CRC_LO;
                        end else begin
                           pop = 1'b1;
                        end
                     end else begin
                        idx_in = idx_ff + 4'd1;
                     end
                  end
                  tfe_pkg::OP_BYTE: begin
                     byte_out = head_cmd.code;
                     feed     = 1'b1;
                     if (head_cmd.close) begin
                        phase_in = tfe_pkg::PH_CRC_LO;
                     end else begin
                        pop = 1'b1;
                     end
                  end
                  tfe_pkg::OP_ERR: begin
                     end_out = 1'b1;
                     err_out = 1'b1;
                     pop     = 1'b1;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
            tfe_pkg::PH_CRC_LO: begin
               byte_out = crc_ff[7:0];
               phase_in = tfe_pkg::PH_CRC_HI;
            end
            tfe_pkg::PH_CRC_HI: begin
               byte_out = crc_ff[15:8];
               end_out  = 1'b1;
               seq_in   = seq_ff + 16'd1;
               phase_in = tfe_pkg::PH_HEAD;
               pop      = 1'b1;
            end
            default: begin
               phase_in = tfe_pkg::PH_HEAD;
            end
         endcase
      end
   end

   // The version byte restarts the CRC, so an abandoned frame leaves no trace.
   always_comb begin
      crc_base = crc_ff;
      if (head_cmd.op == tfe_pkg::OP_START && idx_ff == tfe_pkg::HDR_VERSION) begin
         crc_base = tfe_pkg::CRC_INIT;
      end
      crc_in = crc_ff;
      if (feed) begin
         crc_in = tfe_pkg::crc16_byte(crc_base, byte_out);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tfe_pkg::PH_HEAD;
         idx_ff   <= tfe_pkg::HDR_SOF_FIRST;
         crc_ff   <= tfe_pkg::CRC_INIT;
         seq_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         seq_ff   <= seq_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= byte_out;
         last_ff <= end_out;
         err_ff  <= err_out;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

endmodule

`default_nettype wire

/* sv/typed_frame_encoder_crc16.sv */
// Typed frame encoder with a CRC-16/CCITT-FALSE trailer.
// Input beats (req_) are either a frame start (tuser = 0) carrying record
// type, flags and payload length, or a payload byte (tuser = 1). A valid
// start produces nine header bytes: two start-of-frame markers, version,
// type, flags, sequence number and length, both little-endian. Each payload
// byte passes through; after the last one the CRC follows, low byte first,
// with tlast set. An over-long start or a payload byte outside a frame
// gives a single zero byte with tlast and tuser (error) set.
// An accepted input beat is written into the command queue and its first
// output beat is registered in the sequencer. Input takes one beat per cycle
// while the command queue has room; the output sequencer sends one byte per
// cycle while rsp_tready is high, so a start costs nine (or eleven) output
// bytes and the queue absorbs the difference. Payload bytes sustain one per
// cycle with rsp_tready high, set by the byte-wide CRC update in the sequencer.
// Reset restores the configuration defaults, clears the sequence number and
// empties the queue. When rsp_tready is low the output byte holds, the
// sequencer stalls, and req_tready drops once the queue fills up.
// Configuration writes (csr_) are always accepted and belong to idle time.
`default_nettype none

`include "assert_macros.svh"

module typed_frame_encoder_crc16 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] record_type, [15:8] frame_flags, [31:16] payload_len,
   // [39:32] payload_byte
   input  wire logic [39:0] req_tdata,
   // [0] kind
   input  wire logic        req_tuser,
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]       rsp_tdata,
   // frame_end
   output logic             rsp_tlast,
   // [0] error
   output logic             rsp_tuser,
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [7:0]  sof_first_ff;
   logic [7:0]  sof_second_ff;
   logic [7:0]  proto_version_ff;
   logic [15:0] max_payload_ff;

   logic                accept;
   logic                head_valid;
   logic                pop;
   tfe_pkg::cmd_type    front_cmd;
   tfe_pkg::cmd_type    head_cmd;
   tfe_pkg::q_stat_type q_stat;

   // Configuration registers; writes never stall.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sof_first_ff     <= 8'hAA;
         sof_second_ff    <= 8'h55;
         proto_version_ff <= 8'h01;
         max_payload_ff   <= 16'd256;
      end else if (csr_valid) begin
         case (csr_index)
            tfe_pkg::CSR_SOF_FIRST:     sof_first_ff     <= csr_wdata[7:0];
            tfe_pkg::CSR_SOF_SECOND:    sof_second_ff    <= csr_wdata[7:0];
            tfe_pkg::CSR_PROTO_VERSION: proto_version_ff <= csr_wdata[7:0];
            tfe_pkg::CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The front end takes a beat whenever the queue has a free slot.
   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign head_valid = !q_stat.empty;

   tfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_tuser),
      .record_type  (req_tdata[7:0]),
      .frame_flags  (req_tdata[15:8]),
      .payload_len  (req_tdata[31:16]),
      .payload_byte (req_tdata[39:32]),
      .max_payload  (max_payload_ff),
      .cmd          (front_cmd)
   );

   tfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   tfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .sof_first     (sof_first_ff),
      .sof_second    (sof_second_ff),
      .proto_version (proto_version_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser)
   );

   // An error result is always a lone zero byte that also closes the frame.
   `TFE_ASSERT_IMPLIES(a_err_is_lone_byte, clock, reset, rsp_tvalid && rsp_tuser,
                       rsp_tlast && (rsp_tdata == 8'h00))
   // The sequencer never retires a command from an empty queue.
   `TFE_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, q_stat.pop && q_stat.empty)
   // A full queue never takes another command.
   `TFE_ASSERT_NEVER(a_no_push_when_full, clock, reset, q_stat.push && q_stat.full)

endmodule

`default_nettype wire
